// ----- hdl/swac_pkg.sv -----
// ----------------------------------------------------------------------------
// swac_pkg
// Shared types, constants and helpers for the sliding-window anagram counter.
// ----------------------------------------------------------------------------
package swac_pkg;

    localparam int LETTER_W       = 7;
    localparam int LEN_W          = 13;
    localparam int HIST_W         = 13;
    localparam int MATCH_W        = 24;
    localparam int WINDOW_MAX_DEF = 4096;
    localparam int ALPHABET_DEF   = 128;

    typedef logic [HIST_W-1:0]  hist_t;
    typedef logic [MATCH_W-1:0] match_t;

    localparam hist_t  HIST_MAX  = '1;
    localparam match_t MATCH_MAX = '1;

    typedef enum logic [1:0] {
        KIND_PATTERN = 2'd0,
        KIND_TEXT    = 2'd1,
        KIND_CLEAR   = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [LETTER_W-1:0]  letter;
        logic                 last_text;
    } item_t;

    typedef struct packed {
        logic   window_match;
        match_t match_count;
        logic   is_last;
    } result_t;

    // Per-symbol record kept in the histogram banks
    typedef struct packed {
        hist_t pattern;
        hist_t window;
    } hist_rec_t;

    function automatic hist_t hist_inc(hist_t h);
        return (h == HIST_MAX) ? h : h + hist_t'(1);
    endfunction

    function automatic hist_t hist_dec(hist_t h);
        return (h == '0) ? h : h - hist_t'(1);
    endfunction

endpackage

// ----- hdl/swac_hist_bank.sv -----
// ----------------------------------------------------------------------------
// swac_hist_bank
// One write, two read histogram bank with per-entry valid bits and a
// clear of all entries. Reads are registered and see a write on the same edge.
// ----------------------------------------------------------------------------
module swac_hist_bank #(
    parameter int DEPTH = swac_pkg::ALPHABET_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 clear,
    input  logic                 wr_en,
    input  logic [ADDR_W-1:0]    wr_addr,
    input  swac_pkg::hist_rec_t  wr_data,
    input  logic [ADDR_W-1:0]    rd_addr_0,
    input  logic [ADDR_W-1:0]    rd_addr_1,
    output swac_pkg::hist_rec_t  rd_data_0,
    output swac_pkg::hist_rec_t  rd_data_1
);

    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    swac_pkg::hist_rec_t mem [DEPTH];
    logic [DEPTH-1:0]    valid_reg;
    logic [DEPTH-1:0]    valid_next;
    swac_pkg::hist_rec_t rd_data_0_reg;
    swac_pkg::hist_rec_t rd_data_1_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (wr_en)
        begin
            valid_next[wr_addr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // write-through on address match, never-written entries read as zero
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end

        if (clear)
        begin
            rd_data_0_reg <= '0;
        end
        else if (wr_en && (wr_addr == rd_addr_0))
        begin
            rd_data_0_reg <= wr_data;
        end
        else if (valid_reg[rd_addr_0])
        begin
            rd_data_0_reg <= mem[rd_addr_0];
        end
        else
        begin
            rd_data_0_reg <= '0;
        end

        if (clear)
        begin
            rd_data_1_reg <= '0;
        end
        else if (wr_en && (wr_addr == rd_addr_1))
        begin
            rd_data_1_reg <= wr_data;
        end
        else if (valid_reg[rd_addr_1])
        begin
            rd_data_1_reg <= mem[rd_addr_1];
        end
        else
        begin
            rd_data_1_reg <= '0;
        end
    end

    assign rd_data_0 = rd_data_0_reg;
    assign rd_data_1 = rd_data_1_reg;

endmodule

// ----- hdl/sliding_window_anagram_counter_top.sv -----
// ----------------------------------------------------------------------------
// sliding_window_anagram_counter_top
// Counts text windows that are anagrams of a loaded pattern.
// ----------------------------------------------------------------------------
// Usage:
//   Set pattern_length through cfg_wr_en / cfg_wr_data while the block is idle.
//   Send items on item_valid / item_ready: pattern letters first, then text
//   letters; a clear item empties both histograms and all counts.
//   Every text letter yields one item on result_valid / result_ready with the
//   match flag for the window ending there and the running match count.
//   Pattern and clear items yield nothing.
// Timing:
//   One item is taken per cycle while item_ready is high. Stages, in order:
//   history read, histogram bank read, histogram update.
//   The histograms live in two XOR-combined banks so that the entering and
//   the leaving letter are both updated in the same cycle.
// Reset and stall:
//   Reset clears counts, histograms and pointers; pattern_length returns to 1.
//   A 4-entry result queue absorbs a stalled receiver; item_ready drops once
//   the queue plus items in flight would fill it.
// ----------------------------------------------------------------------------
module sliding_window_anagram_counter_top #(
    parameter int WINDOW_MAX = swac_pkg::WINDOW_MAX_DEF,
    parameter int ALPHABET   = swac_pkg::ALPHABET_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_wr_en,
    input  logic [swac_pkg::LEN_W-1:0]   cfg_wr_data,
    input  logic                         item_valid,
    output logic                         item_ready,
    input  swac_pkg::item_t              item,
    output logic                         result_valid,
    input  logic                         result_ready,
    output swac_pkg::result_t            result
);

    localparam int SYM_W      = (ALPHABET > 1) ? $clog2(ALPHABET) : 1;
    localparam int PTR_W      = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int FILL_W     = $clog2(WINDOW_MAX + 1);
    localparam int DIFF_W     = $clog2(ALPHABET + 1);
    localparam int LETTER_N   = 2 ** swac_pkg::LETTER_W;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    // ------------------------------------------------------------------
    // Configuration
    // ------------------------------------------------------------------
    logic [swac_pkg::LEN_W-1:0] len_reg;
    logic [FILL_W-1:0]          eff_len;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= swac_pkg::LEN_W'(1);
        end
        else if (cfg_wr_en)
        begin
            len_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        if (len_reg == '0)
        begin
            eff_len = FILL_W'(1);
        end
        else if (32'(len_reg) > 32'(WINDOW_MAX))
        begin
            eff_len = FILL_W'(WINDOW_MAX);
        end
        else
        begin
            eff_len = FILL_W'(len_reg);
        end
    end

    // letter to symbol index
    logic [SYM_W-1:0] sym_lut [LETTER_N];

    for (genvar i = 0; i < LETTER_N; i++)
    begin : g_sym_lut
        assign sym_lut[i] = SYM_W'(i % ALPHABET);
    end

    // ------------------------------------------------------------------
    // Front: window fill, history ring
    // ------------------------------------------------------------------
    logic              accept;
    logic [SYM_W-1:0]  in_sym;
    logic              in_remove;
    logic              in_full;
    logic [FILL_W:0]   fill_p1;
    logic [FILL_W:0]   rd_diff;
    logic [PTR_W-1:0]  rd_idx;
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic [PTR_W-1:0]  ptr_reg;
    logic [PTR_W-1:0]  ptr_next;
    logic [SYM_W-1:0]  history_mem [WINDOW_MAX];
    logic [SYM_W-1:0]  hist_rd_reg;

    assign accept    = item_valid && item_ready;
    assign in_sym    = sym_lut[item.letter];
    assign in_remove = (fill_reg >= eff_len);
    assign fill_p1   = (FILL_W+1)'(fill_reg) + (FILL_W+1)'(1);
    assign in_full   = (fill_p1 >= (FILL_W+1)'(eff_len));

    // slot of the letter leaving the window, modulo the ring size
    assign rd_diff = (FILL_W+1)'(ptr_reg) - (FILL_W+1)'(eff_len);
    assign rd_idx  = rd_diff[FILL_W] ? PTR_W'(rd_diff + (FILL_W+1)'(WINDOW_MAX))
                                     : PTR_W'(rd_diff);

    always_comb
    begin
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        if (accept)
        begin
            case (item.kind)
                swac_pkg::KIND_TEXT:
                begin
                    if (!in_remove)
                    begin
                        fill_next = fill_reg + FILL_W'(1);
                    end
                    ptr_next = (ptr_reg == PTR_W'(WINDOW_MAX - 1)) ? '0
                                                                   : ptr_reg + PTR_W'(1);
                end
                swac_pkg::KIND_CLEAR:
                begin
                    fill_next = '0;
                    ptr_next  = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ptr_reg  <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            ptr_reg  <= ptr_next;
        end
    end

    // read-first: with a full-size window the read slot is the write slot
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hist_rd_reg <= history_mem[rd_idx];
            if (item.kind == swac_pkg::KIND_TEXT)
            begin
                history_mem[ptr_reg] <= in_sym;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: item with its leaving letter, bank reads issued
    // ------------------------------------------------------------------
    logic              s1_valid_reg;
    swac_pkg::kind_t   s1_kind_reg;
    logic [SYM_W-1:0]  s1_sym_reg;
    logic              s1_remove_reg;
    logic              s1_full_reg;
    logic              s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_kind_reg   <= item.kind;
            s1_sym_reg    <= in_sym;
            s1_remove_reg <= in_remove;
            s1_full_reg   <= in_full;
            s1_last_reg   <= item.last_text;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: histogram update
    // ------------------------------------------------------------------
    logic              s2_valid_reg;
    swac_pkg::kind_t   s2_kind_reg;
    logic [SYM_W-1:0]  s2_sym_reg;
    logic [SYM_W-1:0]  s2_gone_reg;
    logic              s2_remove_reg;
    logic              s2_full_reg;
    logic              s2_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        s2_kind_reg   <= s1_kind_reg;
        s2_sym_reg    <= s1_sym_reg;
        s2_gone_reg   <= hist_rd_reg;
        s2_remove_reg <= s1_remove_reg;
        s2_full_reg   <= s1_full_reg;
        s2_last_reg   <= s1_last_reg;
    end

    // Bank A is written at the entering symbol, bank B at the leaving one.
    // The stored record is the XOR of both banks.
    logic                bank_clear;
    logic                wr_a_en;
    logic                wr_b_en;
    swac_pkg::hist_rec_t wr_a_data;
    swac_pkg::hist_rec_t wr_b_data;
    swac_pkg::hist_rec_t a_sym;
    swac_pkg::hist_rec_t a_gone;
    swac_pkg::hist_rec_t b_sym;
    swac_pkg::hist_rec_t b_gone;

    swac_hist_bank #(
        .DEPTH     (ALPHABET)
    ) u_bank_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (bank_clear),
        .wr_en     (wr_a_en),
        .wr_addr   (s2_sym_reg),
        .wr_data   (wr_a_data),
        .rd_addr_0 (s1_sym_reg),
        .rd_addr_1 (hist_rd_reg),
        .rd_data_0 (a_sym),
        .rd_data_1 (a_gone)
    );

    swac_hist_bank #(
        .DEPTH     (ALPHABET)
    ) u_bank_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (bank_clear),
        .wr_en     (wr_b_en),
        .wr_addr   (s2_gone_reg),
        .wr_data   (wr_b_data),
        .rd_addr_0 (s1_sym_reg),
        .rd_addr_1 (hist_rd_reg),
        .rd_data_0 (b_sym),
        .rd_data_1 (b_gone)
    );

    swac_pkg::hist_rec_t rec_sym;
    swac_pkg::hist_rec_t rec_gone;
    swac_pkg::hist_t     w_gone_dec;
    swac_pkg::hist_t     w_cur;
    swac_pkg::hist_t     w_new;
    swac_pkg::hist_t     p_new;
    logic                same_sym;
    logic [1:0]          ups;
    logic [1:0]          downs;
    logic                hit;
    logic                push;
    logic [DIFF_W-1:0]   diff_reg;
    logic [DIFF_W-1:0]   diff_next;
    swac_pkg::match_t    match_reg;
    swac_pkg::match_t    match_next;

    assign rec_sym    = a_sym ^ b_sym;
    assign rec_gone   = a_gone ^ b_gone;
    assign w_gone_dec = swac_pkg::hist_dec(rec_gone.window);
    assign same_sym   = s2_remove_reg && (s2_sym_reg == s2_gone_reg);
    // a letter leaving and entering at once sees its own decrement first
    assign w_cur      = same_sym ? w_gone_dec : rec_sym.window;
    assign w_new      = swac_pkg::hist_inc(w_cur);
    assign p_new      = swac_pkg::hist_inc(rec_sym.pattern);

    always_comb
    begin
        bank_clear = 1'b0;
        wr_a_en    = 1'b0;
        wr_b_en    = 1'b0;
        wr_a_data  = b_sym;
        wr_b_data  = a_gone;
        ups        = '0;
        downs      = '0;
        hit        = 1'b0;
        push       = 1'b0;
        diff_next  = diff_reg;
        match_next = match_reg;
        if (s2_valid_reg)
        begin
            case (s2_kind_reg)
                swac_pkg::KIND_PATTERN:
                begin
                    wr_a_en   = 1'b1;
                    wr_a_data = {p_new, rec_sym.window} ^ b_sym;
                    ups[0]    = (p_new != rec_sym.window)
                                && (rec_sym.pattern == rec_sym.window);
                    downs[0]  = (p_new == rec_sym.window)
                                && (rec_sym.pattern != rec_sym.window);
                    diff_next = diff_reg + DIFF_W'(ups) - DIFF_W'(downs);
                end
                swac_pkg::KIND_TEXT:
                begin
                    if (s2_remove_reg)
                    begin
                        ups[0]   = (rec_gone.pattern != w_gone_dec)
                                   && (rec_gone.pattern == rec_gone.window);
                        downs[0] = (rec_gone.pattern == w_gone_dec)
                                   && (rec_gone.pattern != rec_gone.window);
                    end
                    ups[1]    = (rec_sym.pattern != w_new) && (rec_sym.pattern == w_cur);
                    downs[1]  = (rec_sym.pattern == w_new) && (rec_sym.pattern != w_cur);
                    diff_next = diff_reg + DIFF_W'(ups[0]) + DIFF_W'(ups[1])
                                - DIFF_W'(downs[0]) - DIFF_W'(downs[1]);
                    wr_a_en   = 1'b1;
                    wr_a_data = {rec_sym.pattern, w_new} ^ b_sym;
                    wr_b_en   = s2_remove_reg && !same_sym;
                    wr_b_data = {rec_gone.pattern, w_gone_dec} ^ a_gone;
                    hit       = s2_full_reg && (diff_next == '0);
                    if (hit && (match_reg != swac_pkg::MATCH_MAX))
                    begin
                        match_next = match_reg + swac_pkg::match_t'(1);
                    end
                    push = 1'b1;
                end
                swac_pkg::KIND_CLEAR:
                begin
                    bank_clear = 1'b1;
                    diff_next  = '0;
                    match_next = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg  <= '0;
            match_reg <= '0;
        end
        else
        begin
            diff_reg  <= diff_next;
            match_reg <= match_next;
        end
    end

    // ------------------------------------------------------------------
    // Result queue
    // ------------------------------------------------------------------
    swac_pkg::result_t  fifo_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic [CNT_W:0]     reserved;
    logic               pop;

    assign pop          = result_valid && result_ready;
    assign result_valid = (count_reg != '0);
    assign result       = fifo_reg[rd_ptr_reg];

    // every item in flight holds a slot
    assign reserved   = (CNT_W+1)'(count_reg) + (CNT_W+1)'(s1_valid_reg)
                        + (CNT_W+1)'(s2_valid_reg);
    assign item_ready = (reserved < (CNT_W+1)'(FIFO_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{window_match: hit,
                                      match_count:  match_next,
                                      is_last:      s2_last_reg};
        end
    end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sliding-window anagram counter. A directed table
// covers the extremes and the corner cases. It is followed by a pattern-count
// saturation run, and then by random phases. Each phase mostly loads a fresh
// pattern and streams text built from shuffled pattern copies and noise, with
// the window length changed between phases. Results are checked against an
// in-bench model of the histograms and the window, or against typed table rows.
// ----------------------------------------------------------------------------
module testbench;
    import swac_pkg::*;

    localparam int WIN_MAX      = WINDOW_MAX_DEF;
    localparam int ALPHA        = ALPHABET_DEF;
    localparam int RANDOM_ITEMS = 1150;
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = 8;      // longer than the pipeline latency
    localparam int SAT_LOAD     = 8195;   // enough to pin a pattern count at max
    localparam int N_DIRECTED   = 24;

    localparam kind_t KIND_UNUSED = kind_t'(2'd3);

    typedef struct packed {
        kind_t               kind;
        logic [LETTER_W-1:0] letter;
        logic                last;
        logic                typed;    // expected result written out below
        logic                hit;
        match_t              count;
    } step_row_t;

    // Window length is 1 throughout the table (reset value).
    localparam step_row_t DIRECTED [N_DIRECTED] = '{
        '{KIND_TEXT,    7'h41, 1'b0, 1'b1, 1'b0, 24'd0},  // empty pattern
        '{KIND_PATTERN, 7'h41, 1'b1, 1'b0, 1'b0, 24'd0},
        '{KIND_TEXT,    7'h41, 1'b0, 1'b1, 1'b1, 24'd1},
        '{KIND_TEXT,    7'h7A, 1'b0, 1'b1, 1'b0, 24'd1},
        '{KIND_UNUSED,  7'h7F, 1'b1, 1'b0, 1'b0, 24'd0},  // ignored
        '{KIND_TEXT,    7'h7F, 1'b1, 1'b1, 1'b0, 24'd1},
        '{KIND_CLEAR,   7'h7F, 1'b1, 1'b0, 1'b0, 24'd0},
        '{KIND_PATTERN, 7'h00, 1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TEXT,    7'h00, 1'b0, 1'b1, 1'b1, 24'd1},
        '{KIND_TEXT,    7'h7F, 1'b0, 1'b1, 1'b0, 24'd1},
        '{KIND_TEXT,    7'h00, 1'b1, 1'b1, 1'b1, 24'd2},
        '{KIND_CLEAR,   7'h00, 1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TEXT,    7'h00, 1'b0, 1'b1, 1'b0, 24'd0},
        '{KIND_PATTERN, 7'h41, 1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_PATTERN, 7'h7A, 1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TEXT,    7'h41, 1'b0, 1'b1, 1'b0, 24'd0},  // pattern longer than window
        '{KIND_TEXT,    7'h7A, 1'b0, 1'b1, 1'b0, 24'd0},
        '{KIND_PATTERN, 7'h2A, 1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TEXT,    7'h55, 1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TEXT,    7'h2A, 1'b1, 1'b0, 1'b0, 24'd0},
        '{KIND_CLEAR,   7'h55, 1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_PATTERN, 7'h2A, 1'b0, 1'b0, 1'b0, 24'd0},
        '{KIND_TEXT,    7'h2A, 1'b0, 1'b1, 1'b1, 24'd1},
        '{KIND_TEXT,    7'h2A, 1'b1, 1'b1, 1'b1, 24'd2}
    };

    logic               clk;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [LEN_W-1:0]   cfg_wr_data;
    logic               item_valid;
    logic               item_ready;
    item_t              item;
    logic               result_valid;
    logic               result_ready;
    result_t            result;

    // pattern_length is the only configuration register
    sliding_window_anagram_counter_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // Window model
    hist_t              pat_cnt [ALPHA];
    hist_t              win_cnt [ALPHA];
    int                 n_differ;
    int                 fill;
    int                 ring_wr;
    logic [LETTER_W-1:0] ring [WIN_MAX];
    match_t             hits;
    logic [LEN_W-1:0]   win_len;

    result_t            expected_q [$];
    int                 errors;
    int                 items_sent;
    int                 cycles;
    bit                 hold_req;
    bit                 no_gaps;

    logic [LETTER_W-1:0] pattern_q [$];
    logic [LETTER_W-1:0] letter_set [$];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    function automatic void clear_counts();
        foreach (pat_cnt[i])
        begin
            pat_cnt[i] = '0;
            win_cnt[i] = '0;
        end
        n_differ = 0;
        fill     = 0;
        ring_wr  = 0;
        hits     = '0;
    endfunction

    // Saturating +/-1 on one count, keeping the differing-symbol tally in step
    function automatic void adjust(input bit on_pattern, input int sym, input bit up);
        bit    was_diff;
        bit    now_diff;
        hist_t c;
        was_diff = pat_cnt[sym] != win_cnt[sym];
        c = on_pattern ? pat_cnt[sym] : win_cnt[sym];
        if (up)
        begin
            if (c != HIST_MAX)
                c = c + hist_t'(1);
        end
        else if (c != '0)
            c = c - hist_t'(1);
        if (on_pattern)
            pat_cnt[sym] = c;
        else
            win_cnt[sym] = c;
        now_diff = pat_cnt[sym] != win_cnt[sym];
        if (now_diff && !was_diff)
            n_differ++;
        else if (was_diff && !now_diff)
            n_differ--;
    endfunction

    function automatic bit predict_window(input item_t it, output result_t r);
        int sym;
        int span;
        bit hit;
        r   = '0;
        sym = int'(it.letter) % ALPHA;
        if (it.kind == KIND_PATTERN)
        begin
            adjust(1'b1, sym, 1'b1);
            return 1'b0;
        end
        if (it.kind == KIND_CLEAR)
        begin
            clear_counts();
            return 1'b0;
        end
        if (it.kind != KIND_TEXT)
            return 1'b0;

        span = (win_len == 0) ? 1 : ((int'(win_len) > WIN_MAX) ? WIN_MAX : int'(win_len));
        if (fill >= span)
            adjust(1'b0, int'(ring[(ring_wr + WIN_MAX - span) % WIN_MAX]) % ALPHA, 1'b0);
        else
            fill++;
        adjust(1'b0, sym, 1'b1);
        ring[ring_wr] = LETTER_W'(sym);
        ring_wr = (ring_wr + 1) % WIN_MAX;

        hit = (fill >= span) && (n_differ == 0);
        if (hit && hits != MATCH_MAX)
            hits = hits + match_t'(1);
        r.window_match = hit;
        r.match_count  = hits;
        r.is_last      = it.last_text;
        return 1'b1;
    endfunction

    function automatic item_t mk_item(input kind_t k, input logic [LETTER_W-1:0] l,
                                      input logic last);
        item_t it;
        it.kind      = k;
        it.letter    = l;
        it.last_text = last;
        return it;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
        errors++;
    endtask

    task automatic send_item(input item_t it, input bit typed = 1'b0,
                             input result_t typed_r = '0);
        result_t r;
        item       <= it;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (!item_ready);
        if (predict_window(it, r))
            expected_q.push_back(typed ? typed_r : r);
        if (it.kind != KIND_UNUSED)
            items_sent++;
    endtask

    task automatic pause_sender();
        int n;
        n = no_gaps ? 0 : gap_len();
        if (n > 0)
        begin
            item_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        if (item_valid)
            item_valid <= 1'b0;
        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_length(input int v);
        wait_idle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= LEN_W'(v);
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        win_len      = LEN_W'(v);
    endtask

    function automatic logic [LETTER_W-1:0] pick_letter();
        return letter_set[$urandom_range(0, letter_set.size() - 1)];
    endfunction

    // Text letter, sometimes preceded by an ignored item or a late pattern letter
    task automatic send_text(input logic [LETTER_W-1:0] l, input logic last);
        int r;
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            send_item(mk_item(KIND_UNUSED, $urandom_range(0, 127), $urandom_range(0, 1)));
            pause_sender();
        end
        else if (r == 3)
        begin
            send_item(mk_item(KIND_PATTERN, pick_letter(), $urandom_range(0, 1)));
            pause_sender();
        end
        send_item(mk_item(KIND_TEXT, l, last));
        pause_sender();
    endtask

    task automatic run_phase(input bit do_hold);
        int r;
        int len;
        int span;
        int c;
        int j;
        logic [LETTER_W-1:0] text_q [$];
        logic [LETTER_W-1:0] perm [$];
        logic [LETTER_W-1:0] t;

        r = $urandom_range(0, 99);
        if (r < 4)
            len = 0;
        else if (r < 8)
            len = WIN_MAX;
        else if (r < 11)
            len = 8191;
        else if (r < 13)
            len = $urandom_range(WIN_MAX + 1, 8190);
        else if (r < 20)
            len = $urandom_range(20, 64);
        else
            len = $urandom_range(1, 8);
        if (do_hold)
            len = $urandom_range(2, 5);
        set_length(len);
        span = (len == 0) ? 1 : ((len > WIN_MAX) ? WIN_MAX : len);
        no_gaps = do_hold || ($urandom_range(0, 4) == 0);

        // Mostly a fresh pattern; otherwise keep the text going under the new length
        if (pattern_q.size() == 0 || $urandom_range(0, 3) != 0)
        begin
            send_item(mk_item(KIND_CLEAR, $urandom_range(0, 127), $urandom_range(0, 1)));
            pause_sender();
            letter_set.delete();
            repeat ($urandom_range(1, 4)) letter_set.push_back($urandom_range(0, 127));
            pattern_q.delete();
            repeat ((span > 64) ? 8 : span) pattern_q.push_back(pick_letter());
            foreach (pattern_q[i])
            begin
                send_item(mk_item(KIND_PATTERN, pattern_q[i], $urandom_range(0, 1)));
                pause_sender();
            end
        end

        if (span > 64)
            repeat (40) text_q.push_back(pick_letter());
        else
        begin
            repeat ($urandom_range(2, 6))
            begin
                c = $urandom_range(0, 99);
                if (c < 50)
                begin
                    perm = pattern_q;
                    for (int i = perm.size() - 1; i > 0; i--)
                    begin
                        j = $urandom_range(0, i);
                        t = perm[i];
                        perm[i] = perm[j];
                        perm[j] = t;
                    end
                    foreach (perm[i])
                        text_q.push_back(perm[i]);
                end
                else if (c < 80)
                    repeat ($urandom_range(1, span + 2)) text_q.push_back(pick_letter());
                else
                    repeat ($urandom_range(1, 4)) text_q.push_back($urandom_range(0, 127));
            end
        end

        if (do_hold)
        begin
            repeat (30) text_q.push_back(pick_letter());
            hold_req = 1'b1;
        end
        foreach (text_q[i])
            send_text(text_q[i], i == text_q.size() - 1);
    endtask

    // Result side: random stalls, calm stretches, one long hold-off on request
    initial
    begin
        int      stall_left;
        int      calm_left;
        int      hold_left;
        result_t want;
        stall_left = 0;
        calm_left  = 0;
        hold_left  = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result_valid && result_ready)
            begin
                if (expected_q.size() == 0)
                    report_mismatch("result with nothing expected", result.match_count, 0);
                else
                begin
                    want = expected_q.pop_front();
                    if (result.window_match !== want.window_match)
                        report_mismatch("window_match", result.window_match,
                                        want.window_match);
                    if (result.match_count !== want.match_count)
                        report_mismatch("match_count", result.match_count,
                                        want.match_count);
                    if (result.is_last !== want.is_last)
                        report_mismatch("is_last", result.is_last, want.is_last);
                end
            end
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ready <= 1'b0;
            end
            else
            begin
                if (calm_left > 0)
                    calm_left--;
                else if ($urandom_range(0, 99) == 0)
                    calm_left = $urandom_range(50, 200);
                else
                    stall_left = gap_len();
                result_ready <= (stall_left == 0);
            end
        end
    end

    initial
    begin
        int        phase;
        step_row_t row;
        result_t   typed_r;

        errors     = 0;
        items_sent = 0;
        hold_req   = 1'b0;
        no_gaps    = 1'b0;
        win_len    = LEN_W'(1);
        clear_counts();
        foreach (ring[i])
            ring[i] = '0;

        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        item_valid  <= 1'b0;
        item        <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            row = DIRECTED[i];
            typed_r.window_match = row.hit;
            typed_r.match_count  = row.count;
            typed_r.is_last      = row.last;
            send_item(mk_item(row.kind, row.letter, row.last), row.typed, typed_r);
            pause_sender();
        end

        // Drive one pattern count into saturation, then stream a little text
        set_length(WIN_MAX);
        no_gaps = 1'b1;
        send_item(mk_item(KIND_CLEAR, 7'h00, 1'b0));
        repeat (SAT_LOAD) send_item(mk_item(KIND_PATTERN, 7'h55, 1'b0));
        set_length(2);
        send_item(mk_item(KIND_TEXT, 7'h55, 1'b0));
        send_item(mk_item(KIND_TEXT, 7'h55, 1'b0));
        send_item(mk_item(KIND_TEXT, 7'h2A, 1'b1));
        no_gaps = 1'b0;

        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            run_phase(phase == 3);
            phase++;
        end

        // Largest out-of-range length last, so the final write is an extreme
        set_length(8191);
        send_item(mk_item(KIND_TEXT, 7'h7F, 1'b1));
        wait_idle();

        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
